// ===== rtl/iwd_pkg.sv =====
// Shared types and codes for the instruction word decoder.
`default_nettype none

package iwd_pkg;

   localparam int unsigned WORD_W     = 32;
   localparam int unsigned MNEM_W     = 6;
   localparam int unsigned FORM_W     = 4;
   localparam int unsigned REG_W      = 5;
   localparam int unsigned IMM_W      = 16;
   localparam int unsigned TRAP_W     = 26;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 104;

   // primary opcodes, bits 31..26
   localparam logic [5:0] OP_SPECIAL = 6'h00;
   localparam logic [5:0] OP_J       = 6'h02;
   localparam logic [5:0] OP_JAL     = 6'h03;
   localparam logic [5:0] OP_BEQ     = 6'h04;
   localparam logic [5:0] OP_BNE     = 6'h05;
   localparam logic [5:0] OP_BLEZ    = 6'h06;
   localparam logic [5:0] OP_BGTZ    = 6'h07;
   localparam logic [5:0] OP_ADDI    = 6'h08;
   localparam logic [5:0] OP_ADDIU   = 6'h09;
   localparam logic [5:0] OP_SLTI    = 6'h0A;
   localparam logic [5:0] OP_ANDI    = 6'h0C;
   localparam logic [5:0] OP_ORI     = 6'h0D;
   localparam logic [5:0] OP_XORI    = 6'h0E;
   localparam logic [5:0] OP_LLO     = 6'h18;
   localparam logic [5:0] OP_LHI     = 6'h19;
   localparam logic [5:0] OP_TRAP    = 6'h1A;
   localparam logic [5:0] OP_LB      = 6'h20;
   localparam logic [5:0] OP_LH      = 6'h21;
   localparam logic [5:0] OP_LW      = 6'h23;
   localparam logic [5:0] OP_LBU     = 6'h24;
   localparam logic [5:0] OP_LHU     = 6'h25;
   localparam logic [5:0] OP_SB      = 6'h28;
   localparam logic [5:0] OP_SH      = 6'h29;
   localparam logic [5:0] OP_SW      = 6'h2B;

   // function field codes, bits 5..0, for the special opcode
   localparam logic [5:0] FN_SLL   = 6'h00;
   localparam logic [5:0] FN_SRL   = 6'h02;
   localparam logic [5:0] FN_SRA   = 6'h03;
   localparam logic [5:0] FN_SLLV  = 6'h04;
   localparam logic [5:0] FN_SRLV  = 6'h06;
   localparam logic [5:0] FN_SRAV  = 6'h07;
   localparam logic [5:0] FN_JR    = 6'h08;
   localparam logic [5:0] FN_JALR  = 6'h09;
   localparam logic [5:0] FN_MFHI  = 6'h10;
   localparam logic [5:0] FN_MTHI  = 6'h11;
   localparam logic [5:0] FN_MFLO  = 6'h12;
   localparam logic [5:0] FN_MTLO  = 6'h13;
   localparam logic [5:0] FN_MULT  = 6'h18;
   localparam logic [5:0] FN_MULTU = 6'h19;
   localparam logic [5:0] FN_DIV   = 6'h1A;
   localparam logic [5:0] FN_DIVU  = 6'h1B;
   localparam logic [5:0] FN_ADD   = 6'h20;
   localparam logic [5:0] FN_ADDU  = 6'h21;
   localparam logic [5:0] FN_SUB   = 6'h22;
   localparam logic [5:0] FN_SUBU  = 6'h23;
   localparam logic [5:0] FN_AND   = 6'h24;
   localparam logic [5:0] FN_OR    = 6'h25;
   localparam logic [5:0] FN_XOR   = 6'h26;
   localparam logic [5:0] FN_NOR   = 6'h27;
   localparam logic [5:0] FN_SLTU  = 6'h29;
   localparam logic [5:0] FN_SLT   = 6'h2A;

   // mnemonic codes
   localparam logic [5:0] MN_UNKNOWN = 6'd0;
   localparam logic [5:0] MN_ADD     = 6'd1;
   localparam logic [5:0] MN_ADDU    = 6'd2;
   localparam logic [5:0] MN_AND     = 6'd3;
   localparam logic [5:0] MN_NOR     = 6'd4;
   localparam logic [5:0] MN_OR      = 6'd5;
   localparam logic [5:0] MN_SUB     = 6'd6;
   localparam logic [5:0] MN_SUBU    = 6'd7;
   localparam logic [5:0] MN_XOR     = 6'd8;
   localparam logic [5:0] MN_SLT     = 6'd9;
   localparam logic [5:0] MN_SLTU    = 6'd10;
   localparam logic [5:0] MN_DIV     = 6'd11;
   localparam logic [5:0] MN_DIVU    = 6'd12;
   localparam logic [5:0] MN_MULT    = 6'd13;
   localparam logic [5:0] MN_MULTU   = 6'd14;
   localparam logic [5:0] MN_SLL     = 6'd15;
   localparam logic [5:0] MN_SRA     = 6'd16;
   localparam logic [5:0] MN_SRL     = 6'd17;
   localparam logic [5:0] MN_SLLV    = 6'd18;
   localparam logic [5:0] MN_SRAV    = 6'd19;
   localparam logic [5:0] MN_SRLV    = 6'd20;
   localparam logic [5:0] MN_JALR    = 6'd21;
   localparam logic [5:0] MN_JR      = 6'd22;
   localparam logic [5:0] MN_MFHI    = 6'd23;
   localparam logic [5:0] MN_MFLO    = 6'd24;
   localparam logic [5:0] MN_MTHI    = 6'd25;
   localparam logic [5:0] MN_MTLO    = 6'd26;
   localparam logic [5:0] MN_ADDI    = 6'd27;
   localparam logic [5:0] MN_ADDIU   = 6'd28;
   localparam logic [5:0] MN_ANDI    = 6'd29;
   localparam logic [5:0] MN_ORI     = 6'd30;
   localparam logic [5:0] MN_XORI    = 6'd31;
   localparam logic [5:0] MN_SLTI    = 6'd32;
   localparam logic [5:0] MN_LHI     = 6'd33;
   localparam logic [5:0] MN_LLO     = 6'd34;
   localparam logic [5:0] MN_BEQ     = 6'd35;
   localparam logic [5:0] MN_BNE     = 6'd36;
   localparam logic [5:0] MN_BGTZ    = 6'd37;
   localparam logic [5:0] MN_BLEZ    = 6'd38;
   localparam logic [5:0] MN_LB      = 6'd39;
   localparam logic [5:0] MN_LBU     = 6'd40;
   localparam logic [5:0] MN_LH      = 6'd41;
   localparam logic [5:0] MN_LHU     = 6'd42;
   localparam logic [5:0] MN_LW      = 6'd43;
   localparam logic [5:0] MN_SB      = 6'd44;
   localparam logic [5:0] MN_SH      = 6'd45;
   localparam logic [5:0] MN_SW      = 6'd46;
   localparam logic [5:0] MN_J       = 6'd47;
   localparam logic [5:0] MN_JAL     = 6'd48;
   localparam logic [5:0] MN_TRAP    = 6'd49;
   localparam logic [5:0] MN_LAST    = MN_TRAP;

   // operand forms
   localparam logic [3:0] FORM_NONE      = 4'd0;
   localparam logic [3:0] FORM_DST       = 4'd1;
   localparam logic [3:0] FORM_ST        = 4'd2;
   localparam logic [3:0] FORM_DT_SHAMT  = 4'd3;
   localparam logic [3:0] FORM_DTS       = 4'd4;
   localparam logic [3:0] FORM_S         = 4'd5;
   localparam logic [3:0] FORM_D         = 4'd6;
   localparam logic [3:0] FORM_TS_IMM    = 4'd7;
   localparam logic [3:0] FORM_T_IMM     = 4'd8;
   localparam logic [3:0] FORM_ST_LABEL  = 4'd9;
   localparam logic [3:0] FORM_S_LABEL   = 4'd10;
   localparam logic [3:0] FORM_T_IMM_S   = 4'd11;
   localparam logic [3:0] FORM_JUMP      = 4'd12;
   localparam logic [3:0] FORM_TRAP_CODE = 4'd13;

   typedef struct packed {
      logic [WORD_W-1:0] instruction_word;
      logic [WORD_W-1:0] instruction_address;
   } item_type;

   typedef struct packed {
      logic [MNEM_W-1:0] mnemonic;
      logic [FORM_W-1:0] operand_form;
      logic [REG_W-1:0]  source_reg;
      logic [REG_W-1:0]  target_reg;
      logic [REG_W-1:0]  dest_reg;
      logic [REG_W-1:0]  shift_amount;
      logic [IMM_W-1:0]  immediate_value;
      logic [WORD_W-1:0] branch_or_jump_target;
      logic [TRAP_W-1:0] trap_code;
   } decoded_type;

endpackage

`default_nettype wire

// ===== rtl/iwd_input_reg.sv =====
// Input register stage holding one instruction item ahead of the decoder.
`default_nettype none

module iwd_input_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire iwd_pkg::item_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output iwd_pkg::item_type      out_item
);

   logic              valid_ff;
   logic              valid_in;
   iwd_pkg::item_type item_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/iwd_decoder.sv =====
// Combinational decode of one instruction word into mnemonic, form, fields and target.
`default_nettype none

module iwd_decoder (
   input  wire iwd_pkg::item_type item,
   output iwd_pkg::decoded_type   decoded
);

   logic [5:0]  opcode;
   logic [5:0]  funct;
   logic [15:0] imm;
   logic [5:0]  mnem;
   logic [3:0]  form;
   logic [31:0] branch_offset;
   logic [31:0] target;

   assign opcode        = item.instruction_word[31:26];
   assign funct         = item.instruction_word[5:0];
   assign imm           = item.instruction_word[15:0];
   assign branch_offset = {{14{imm[15]}}, imm, 2'b00};

   always_comb begin
      mnem = iwd_pkg::MN_UNKNOWN;
      form = iwd_pkg::FORM_NONE;
      if (opcode == iwd_pkg::OP_SPECIAL) begin
         unique case (funct)
            iwd_pkg::FN_ADD:   begin mnem = iwd_pkg::MN_ADD;   form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_ADDU:  begin mnem = iwd_pkg::MN_ADDU;  form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_AND:   begin mnem = iwd_pkg::MN_AND;   form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_NOR:   begin mnem = iwd_pkg::MN_NOR;   form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_OR:    begin mnem = iwd_pkg::MN_OR;    form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_SUB:   begin mnem = iwd_pkg::MN_SUB;   form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_SUBU:  begin mnem = iwd_pkg::MN_SUBU;  form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_XOR:   begin mnem = iwd_pkg::MN_XOR;   form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_SLT:   begin mnem = iwd_pkg::MN_SLT;   form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_SLTU:  begin mnem = iwd_pkg::MN_SLTU;  form = iwd_pkg::FORM_DST; end
            iwd_pkg::FN_DIV:   begin mnem = iwd_pkg::MN_DIV;   form = iwd_pkg::FORM_ST; end
            iwd_pkg::FN_DIVU:  begin mnem = iwd_pkg::MN_DIVU;  form = iwd_pkg::FORM_ST; end
            iwd_pkg::FN_MULT:  begin mnem = iwd_pkg::MN_MULT;  form = iwd_pkg::FORM_ST; end
            iwd_pkg::FN_MULTU: begin mnem = iwd_pkg::MN_MULTU; form = iwd_pkg::FORM_ST; end
            iwd_pkg::FN_SLL:   begin mnem = iwd_pkg::MN_SLL;   form = iwd_pkg::FORM_DT_SHAMT; end
            iwd_pkg::FN_SRA:   begin mnem = iwd_pkg::MN_SRA;   form = iwd_pkg::FORM_DT_SHAMT; end
            iwd_pkg::FN_SRL:   begin mnem = iwd_pkg::MN_SRL;   form = iwd_pkg::FORM_DT_SHAMT; end
            iwd_pkg::FN_SLLV:  begin mnem = iwd_pkg::MN_SLLV;  form = iwd_pkg::FORM_DTS; end
            iwd_pkg::FN_SRAV:  begin mnem = iwd_pkg::MN_SRAV;  form = iwd_pkg::FORM_DTS; end
            iwd_pkg::FN_SRLV:  begin mnem = iwd_pkg::MN_SRLV;  form = iwd_pkg::FORM_DTS; end
            iwd_pkg::FN_JALR:  begin mnem = iwd_pkg::MN_JALR;  form = iwd_pkg::FORM_S; end
            iwd_pkg::FN_JR:    begin mnem = iwd_pkg::MN_JR;    form = iwd_pkg::FORM_S; end
            iwd_pkg::FN_MFHI:  begin mnem = iwd_pkg::MN_MFHI;  form = iwd_pkg::FORM_D; end
            iwd_pkg::FN_MFLO:  begin mnem = iwd_pkg::MN_MFLO;  form = iwd_pkg::FORM_D; end
            iwd_pkg::FN_MTHI:  begin mnem = iwd_pkg::MN_MTHI;  form = iwd_pkg::FORM_S; end
            iwd_pkg::FN_MTLO:  begin mnem = iwd_pkg::MN_MTLO;  form = iwd_pkg::FORM_S; end
            default: begin
               mnem = iwd_pkg::MN_UNKNOWN;
               form = iwd_pkg::FORM_NONE;
            end
         endcase
      end else begin
         unique case (opcode)
            iwd_pkg::OP_ADDI:  begin mnem = iwd_pkg::MN_ADDI;  form = iwd_pkg::FORM_TS_IMM; end
            iwd_pkg::OP_ADDIU: begin mnem = iwd_pkg::MN_ADDIU; form = iwd_pkg::FORM_TS_IMM; end
            iwd_pkg::OP_ANDI:  begin mnem = iwd_pkg::MN_ANDI;  form = iwd_pkg::FORM_TS_IMM; end
            iwd_pkg::OP_ORI:   begin mnem = iwd_pkg::MN_ORI;   form = iwd_pkg::FORM_TS_IMM; end
            iwd_pkg::OP_XORI:  begin mnem = iwd_pkg::MN_XORI;  form = iwd_pkg::FORM_TS_IMM; end
            iwd_pkg::OP_SLTI:  begin mnem = iwd_pkg::MN_SLTI;  form = iwd_pkg::FORM_TS_IMM; end
            iwd_pkg::OP_LHI:   begin mnem = iwd_pkg::MN_LHI;   form = iwd_pkg::FORM_T_IMM; end
            iwd_pkg::OP_LLO:   begin mnem = iwd_pkg::MN_LLO;   form = iwd_pkg::FORM_T_IMM; end
            iwd_pkg::OP_BEQ:   begin mnem = iwd_pkg::MN_BEQ;   form = iwd_pkg::FORM_ST_LABEL; end
            iwd_pkg::OP_BNE:   begin mnem = iwd_pkg::MN_BNE;   form = iwd_pkg::FORM_ST_LABEL; end
            iwd_pkg::OP_BGTZ:  begin mnem = iwd_pkg::MN_BGTZ;  form = iwd_pkg::FORM_S_LABEL; end
            iwd_pkg::OP_BLEZ:  begin mnem = iwd_pkg::MN_BLEZ;  form = iwd_pkg::FORM_S_LABEL; end
            iwd_pkg::OP_LB:    begin mnem = iwd_pkg::MN_LB;    form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_LBU:   begin mnem = iwd_pkg::MN_LBU;   form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_LH:    begin mnem = iwd_pkg::MN_LH;    form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_LHU:   begin mnem = iwd_pkg::MN_LHU;   form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_LW:    begin mnem = iwd_pkg::MN_LW;    form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_SB:    begin mnem = iwd_pkg::MN_SB;    form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_SH:    begin mnem = iwd_pkg::MN_SH;    form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_SW:    begin mnem = iwd_pkg::MN_SW;    form = iwd_pkg::FORM_T_IMM_S; end
            iwd_pkg::OP_J:     begin mnem = iwd_pkg::MN_J;     form = iwd_pkg::FORM_JUMP; end
            iwd_pkg::OP_JAL:   begin mnem = iwd_pkg::MN_JAL;   form = iwd_pkg::FORM_JUMP; end
            iwd_pkg::OP_TRAP:  begin mnem = iwd_pkg::MN_TRAP;  form = iwd_pkg::FORM_TRAP_CODE; end
            default: begin
               mnem = iwd_pkg::MN_UNKNOWN;
               form = iwd_pkg::FORM_NONE;
            end
         endcase
      end
   end

   always_comb begin
      case (form)
         iwd_pkg::FORM_ST_LABEL, iwd_pkg::FORM_S_LABEL: begin
            target = item.instruction_address + 32'd4 + branch_offset;
         end
         iwd_pkg::FORM_JUMP: begin
            target = {item.instruction_address[31:28], item.instruction_word[25:0], 2'b00};
         end
         default: begin
            target = '0;
         end
      endcase
   end

   always_comb begin
      decoded.mnemonic              = mnem;
      decoded.operand_form          = form;
      decoded.source_reg            = item.instruction_word[25:21];
      decoded.target_reg            = item.instruction_word[20:16];
      decoded.dest_reg              = item.instruction_word[15:11];
      decoded.shift_amount          = item.instruction_word[10:6];
      decoded.immediate_value       = imm;
      decoded.branch_or_jump_target = target;
      decoded.trap_code             = item.instruction_word[25:0];
   end

endmodule

`default_nettype wire

// ===== rtl/iwd_output_reg.sv =====
// Result register stage holding one decoded item until the consumer takes it.
`default_nettype none

module iwd_output_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire iwd_pkg::decoded_type in_result,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output iwd_pkg::decoded_type      out_result
);

   logic                 valid_ff;
   logic                 valid_in;
   iwd_pkg::decoded_type result_ff;

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         result_ff <= in_result;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/instruction_word_decoder_unit.sv =====
// An accepted req item passes the input register, then the result register, before rsp_tvalid rises.
// Throughput: one item per cycle while rsp_tready is high; decode is one table match and target add.
// req_tready falls only when both stages hold items and rsp_tready is low.
// Reset: synchronous, active high; clears both stage valid flags, no item is lost after it.
// Payload registers are not reset.
`default_nettype none

module instruction_word_decoder_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // instruction_word[31:0], instruction_address[63:32]
   input  wire logic [iwd_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // mnemonic[5:0], operand_form[9:6], source_reg[14:10], target_reg[19:15],
   // dest_reg[24:20], shift_amount[29:25], immediate_value[45:30],
   // branch_or_jump_target[77:46], trap_code[103:78]
   output logic [iwd_pkg::RSP_DATA_W-1:0]          rsp_tdata
);

   iwd_pkg::item_type    req_item;
   iwd_pkg::item_type    held_item;
   iwd_pkg::decoded_type decoded;
   iwd_pkg::decoded_type rsp_result;
   logic                 held_valid;
   logic                 result_ready;

   assign req_item.instruction_word    = req_tdata[31:0];
   assign req_item.instruction_address = req_tdata[63:32];

   iwd_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (held_valid),
      .out_ready (result_ready),
      .out_item  (held_item)
   );

   iwd_decoder u_decoder (
      .item    (held_item),
      .decoded (decoded)
   );

   iwd_output_reg u_output_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (held_valid),
      .in_ready   (result_ready),
      .in_result  (decoded),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_result)
   );

   assign rsp_tdata = {rsp_result.trap_code,
                       rsp_result.branch_or_jump_target,
                       rsp_result.immediate_value,
                       rsp_result.shift_amount,
                       rsp_result.dest_reg,
                       rsp_result.target_reg,
                       rsp_result.source_reg,
                       rsp_result.operand_form,
                       rsp_result.mnemonic};

endmodule

`default_nettype wire

// ===== rtl/iwd_checker.sv =====
// Port-level checks for the instruction word decoder and their bind to the top level.
`default_nettype none

module iwd_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [iwd_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [5:0]  mnem;
   logic [3:0]  form;
   logic [31:0] target;

   assign mnem   = rsp_tdata[5:0];
   assign form   = rsp_tdata[9:6];
   assign target = rsp_tdata[77:46];

   // hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp item changed or dropped");

   // empty result stage must leave the input open
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty result stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (mnem <= iwd_pkg::MN_LAST)
                     && ((mnem == iwd_pkg::MN_UNKNOWN) == (form == iwd_pkg::FORM_NONE)))
      else $error("mnemonic and operand form disagree");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && form != iwd_pkg::FORM_ST_LABEL && form != iwd_pkg::FORM_S_LABEL
         && form != iwd_pkg::FORM_JUMP |-> target == 32'd0)
      else $error("target set for a non-branch item");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

endmodule

bind instruction_word_decoder_unit iwd_checker u_iwd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== tb/sv/instruction_word_decoder_unit_test.sv =====
// Testbench for instruction_word_decoder_unit: directed and random words checked against a decode table.
module instruction_word_decoder_unit_test;
   import iwd_pkg::*;

   localparam logic [5:0] OP_UNUSED = 6'h3F;
   localparam logic [5:0] FN_UNUSED = 6'h3F;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   item_type pending_words [$];
   decoded_type expected_decodes [$];
   int issued_count = 0;
   int accepted_count = 0;
   int mismatch_count = 0;
   int send_gap = 0;
   int rsp_stall = 0;
   bit quiet = 1'b0;

   logic [5:0] funct_codes [26] = '{FN_ADD, FN_ADDU, FN_AND, FN_NOR, FN_OR, FN_SUB, FN_SUBU,
      FN_XOR, FN_SLT, FN_SLTU, FN_DIV, FN_DIVU, FN_MULT, FN_MULTU, FN_SLL, FN_SRA, FN_SRL,
      FN_SLLV, FN_SRAV, FN_SRLV, FN_JALR, FN_JR, FN_MFHI, FN_MFLO, FN_MTHI, FN_MTLO};
   logic [5:0] opcodes [23] = '{OP_ADDI, OP_ADDIU, OP_ANDI, OP_ORI, OP_XORI, OP_SLTI, OP_LHI,
      OP_LLO, OP_BEQ, OP_BNE, OP_BGTZ, OP_BLEZ, OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_SB,
      OP_SH, OP_SW, OP_J, OP_JAL, OP_TRAP};

   instruction_word_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic decoded_type decode_word(logic [31:0] word, logic [31:0] addr);
      decoded_type d;
      logic [5:0] mn;
      logic [3:0] fm;
      logic [31:0] offset;
      mn = MN_UNKNOWN;
      fm = FORM_NONE;
      if (word[31:26] == OP_SPECIAL) begin
         case (word[5:0])
            FN_ADD:   begin mn = MN_ADD;   fm = FORM_DST; end
            FN_ADDU:  begin mn = MN_ADDU;  fm = FORM_DST; end
            FN_AND:   begin mn = MN_AND;   fm = FORM_DST; end
            FN_NOR:   begin mn = MN_NOR;   fm = FORM_DST; end
            FN_OR:    begin mn = MN_OR;    fm = FORM_DST; end
            FN_SUB:   begin mn = MN_SUB;   fm = FORM_DST; end
            FN_SUBU:  begin mn = MN_SUBU;  fm = FORM_DST; end
            FN_XOR:   begin mn = MN_XOR;   fm = FORM_DST; end
            FN_SLT:   begin mn = MN_SLT;   fm = FORM_DST; end
            FN_SLTU:  begin mn = MN_SLTU;  fm = FORM_DST; end
            FN_DIV:   begin mn = MN_DIV;   fm = FORM_ST; end
            FN_DIVU:  begin mn = MN_DIVU;  fm = FORM_ST; end
            FN_MULT:  begin mn = MN_MULT;  fm = FORM_ST; end
            FN_MULTU: begin mn = MN_MULTU; fm = FORM_ST; end
            FN_SLL:   begin mn = MN_SLL;   fm = FORM_DT_SHAMT; end
            FN_SRA:   begin mn = MN_SRA;   fm = FORM_DT_SHAMT; end
            FN_SRL:   begin mn = MN_SRL;   fm = FORM_DT_SHAMT; end
            FN_SLLV:  begin mn = MN_SLLV;  fm = FORM_DTS; end
            FN_SRAV:  begin mn = MN_SRAV;  fm = FORM_DTS; end
            FN_SRLV:  begin mn = MN_SRLV;  fm = FORM_DTS; end
            FN_JALR:  begin mn = MN_JALR;  fm = FORM_S; end
            FN_JR:    begin mn = MN_JR;    fm = FORM_S; end
            FN_MFHI:  begin mn = MN_MFHI;  fm = FORM_D; end
            FN_MFLO:  begin mn = MN_MFLO;  fm = FORM_D; end
            FN_MTHI:  begin mn = MN_MTHI;  fm = FORM_S; end
            FN_MTLO:  begin mn = MN_MTLO;  fm = FORM_S; end
            default: ;
         endcase
      end else begin
         case (word[31:26])
            OP_ADDI:  begin mn = MN_ADDI;  fm = FORM_TS_IMM; end
            OP_ADDIU: begin mn = MN_ADDIU; fm = FORM_TS_IMM; end
            OP_ANDI:  begin mn = MN_ANDI;  fm = FORM_TS_IMM; end
            OP_ORI:   begin mn = MN_ORI;   fm = FORM_TS_IMM; end
            OP_XORI:  begin mn = MN_XORI;  fm = FORM_TS_IMM; end
            OP_SLTI:  begin mn = MN_SLTI;  fm = FORM_TS_IMM; end
            OP_LHI:   begin mn = MN_LHI;   fm = FORM_T_IMM; end
            OP_LLO:   begin mn = MN_LLO;   fm = FORM_T_IMM; end
            OP_BEQ:   begin mn = MN_BEQ;   fm = FORM_ST_LABEL; end
            OP_BNE:   begin mn = MN_BNE;   fm = FORM_ST_LABEL; end
            OP_BGTZ:  begin mn = MN_BGTZ;  fm = FORM_S_LABEL; end
            OP_BLEZ:  begin mn = MN_BLEZ;  fm = FORM_S_LABEL; end
            OP_LB:    begin mn = MN_LB;    fm = FORM_T_IMM_S; end
            OP_LBU:   begin mn = MN_LBU;   fm = FORM_T_IMM_S; end
            OP_LH:    begin mn = MN_LH;    fm = FORM_T_IMM_S; end
            OP_LHU:   begin mn = MN_LHU;   fm = FORM_T_IMM_S; end
            OP_LW:    begin mn = MN_LW;    fm = FORM_T_IMM_S; end
            OP_SB:    begin mn = MN_SB;    fm = FORM_T_IMM_S; end
            OP_SH:    begin mn = MN_SH;    fm = FORM_T_IMM_S; end
            OP_SW:    begin mn = MN_SW;    fm = FORM_T_IMM_S; end
            OP_J:     begin mn = MN_J;     fm = FORM_JUMP; end
            OP_JAL:   begin mn = MN_JAL;   fm = FORM_JUMP; end
            OP_TRAP:  begin mn = MN_TRAP;  fm = FORM_TRAP_CODE; end
            default: ;
         endcase
      end
      d.mnemonic = mn;
      d.operand_form = fm;
      d.source_reg = word[25:21];
      d.target_reg = word[20:16];
      d.dest_reg = word[15:11];
      d.shift_amount = word[10:6];
      d.immediate_value = word[15:0];
      d.trap_code = word[25:0];
      d.branch_or_jump_target = '0;
      if (fm == FORM_ST_LABEL || fm == FORM_S_LABEL) begin
         offset = {{16{word[15]}}, word[15:0]};
         d.branch_or_jump_target = addr + 32'd4 + (offset << 2);
      end else if (fm == FORM_JUMP) begin
         d.branch_or_jump_target = {addr[31:28], word[25:0], 2'b00};
      end
      return d;
   endfunction

   function automatic logic [31:0] random_address();
      logic [31:0] a;
      a = $urandom;
      case ($urandom_range(0, 9))
         0: a = 32'hFFFF_FFFC - 4 * $urandom_range(0, 63);
         1: a = 4 * $urandom_range(0, 63);
         2: ;
         default: a[1:0] = 2'b00;
      endcase
      return a;
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      int k;
      w = $urandom;
      k = $urandom_range(0, 99);
      if (k < 40) w = {OP_SPECIAL, w[25:6], funct_codes[$urandom_range(0, 25)]};
      else if (k < 88) w[31:26] = opcodes[$urandom_range(0, 22)];
      return w;
   endfunction

   task automatic queue_word(logic [31:0] word, logic [31:0] addr);
      item_type it;
      it.instruction_word = word;
      it.instruction_address = addr;
      pending_words.push_back(it);
   endtask

   task automatic drain_decoder();
      while (pending_words.size() != 0 || issued_count != accepted_count ||
             expected_decodes.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
   endtask

   // driver: hold each item until taken, insert random gaps between items while not quiet
   always @(negedge clock) begin
      item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || issued_count == accepted_count) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            send_gap = $urandom_range(0, 5);
            req_tvalid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            it = pending_words.pop_front();
            req_tdata <= {it.instruction_address, it.instruction_word};
            req_tvalid <= 1'b1;
            issued_count++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side: stall in random bursts while not quiet
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_stall = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: check results, predict each accepted item
   always @(posedge clock) begin
      decoded_type got;
      decoded_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.mnemonic = rsp_tdata[5:0];
            got.operand_form = rsp_tdata[9:6];
            got.source_reg = rsp_tdata[14:10];
            got.target_reg = rsp_tdata[19:15];
            got.dest_reg = rsp_tdata[24:20];
            got.shift_amount = rsp_tdata[29:25];
            got.immediate_value = rsp_tdata[45:30];
            got.branch_or_jump_target = rsp_tdata[77:46];
            got.trap_code = rsp_tdata[103:78];
            if (expected_decodes.size() == 0) begin
               report_mismatch("result item with nothing pending");
            end else begin
               want = expected_decodes.pop_front();
               compare_field("mnemonic", got.mnemonic, want.mnemonic);
               compare_field("operand_form", got.operand_form, want.operand_form);
               compare_field("source_reg", got.source_reg, want.source_reg);
               compare_field("target_reg", got.target_reg, want.target_reg);
               compare_field("dest_reg", got.dest_reg, want.dest_reg);
               compare_field("shift_amount", got.shift_amount, want.shift_amount);
               compare_field("immediate_value", got.immediate_value, want.immediate_value);
               compare_field("branch_or_jump_target", got.branch_or_jump_target,
                             want.branch_or_jump_target);
               compare_field("trap_code", got.trap_code, want.trap_code);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_decodes.push_back(decode_word(req_tdata[31:0], req_tdata[63:32]));
            accepted_count++;
         end
      end
   end

   initial begin
      queue_word(32'h0000_0000, 32'h0000_0000);
      queue_word({OP_UNUSED, 26'h3FF_FFFF}, 32'hFFFF_FFFC);
      queue_word({OP_SPECIAL, 20'hF_FFFF, FN_UNUSED}, 32'h1234_5678);
      queue_word({OP_BEQ, 5'd31, 5'd0, 16'h7FFF}, 32'hFFFF_FFFC);
      queue_word({OP_BNE, 5'd0, 5'd31, 16'h8000}, 32'h0000_0000);
      queue_word({OP_BGTZ, 5'd7, 5'd0, 16'hFFFF}, 32'h0000_0010);
      queue_word({OP_BLEZ, 5'd9, 5'd0, 16'h0000}, 32'h0000_0013);
      queue_word({OP_J, 26'h3FF_FFFF}, 32'hF000_0000);
      queue_word({OP_JAL, 26'h000_0000}, 32'h8FFF_FFFF);
      queue_word({OP_TRAP, 26'h3FF_FFFF}, 32'h0000_0000);
      queue_word({OP_TRAP, 26'h000_0000}, 32'hFFFF_FFFF);
      queue_word({OP_LHI, 5'd0, 5'd31, 16'hFFFF}, 32'h0040_0000);
      queue_word({OP_LLO, 5'd31, 5'd0, 16'h0000}, 32'h0040_0004);
      queue_word({OP_ADDI, 5'd1, 5'd2, 16'h8000}, 32'h0040_0008);
      queue_word({OP_SW, 5'd29, 5'd31, 16'hFFFC}, 32'h0040_000C);
      queue_word({OP_LB, 5'd31, 5'd1, 16'h0001}, 32'h0040_0010);
      queue_word({OP_SPECIAL, 5'd31, 5'd31, 5'd31, 5'd0, FN_ADD}, 32'h0040_0014);
      queue_word({OP_SPECIAL, 5'd0, 5'd31, 5'd1, 5'd31, FN_SRA}, 32'h0040_0018);
      queue_word({OP_SPECIAL, 5'd3, 5'd4, 5'd0, 5'd0, FN_DIVU}, 32'h0040_001C);
      queue_word({OP_SPECIAL, 5'd31, 15'h0000, FN_JR}, 32'h0040_0020);
      queue_word({OP_SPECIAL, 10'h000, 5'd31, 5'd0, FN_MFLO}, 32'h0040_0024);
      queue_word({OP_SPECIAL, 5'd5, 5'd6, 5'd7, 5'd0, FN_SLLV}, 32'h0040_0028);
      queue_word({OP_SPECIAL, 5'd8, 15'h7FFF, FN_MTHI}, 32'h0040_002C);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // wait until every directed item is sent and its result is back
      drain_decoder();
      for (int i = 0; i < 49; i++) begin
         logic [31:0] w;
         w = $urandom;
         if (i < 26) w = {OP_SPECIAL, w[25:6], funct_codes[i]};
         else w[31:26] = opcodes[i - 26];
         queue_word(w, random_address());
      end
      for (int i = 0; i < 760; i++) queue_word(random_word(), random_address());

      drain_decoder();
      quiet = 1'b1;
      for (int i = 0; i < 120; i++) queue_word(random_word(), random_address());

      drain_decoder();
      repeat (12) @(posedge clock);
      if (mismatch_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
